@@ rtl/b64_pkg.sv @@
`timescale 1ns / 1ps

package b64_pkg;

  localparam int GroupBits = 24;
  localparam int MaxResults = 4;

  localparam logic OpEncode = 1'b0;
  localparam logic OpDecode = 1'b1;

  localparam logic [7:0] CharPad = 8'h3D;  // '='

  typedef struct packed {
    logic [7:0] data_in;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_of_run;
    logic       bad_char;
  } out_t;

  // One group's worth of results, handed from the group logic to the output stage.
  typedef struct packed {
    logic                  vld;
    logic [3:0][7:0]       chars;
    logic [2:0]            cnt;
    logic                  bad;
  } b64_bundle_t;

  typedef struct packed {
    logic [5:0] val;
    logic       pad;
    logic       bad;
  } dec_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v < 6'd26) begin
        enc_char = w + 8'd65;
      end else if (v < 6'd52) begin
        enc_char = w + 8'd71;   // 'a' - 26
      end else if (v < 6'd62) begin
        enc_char = w - 8'd4;    // '0' - 52
      end else if (v == 6'd62) begin
        enc_char = 8'h2B;
      end else begin
        enc_char = 8'h2F;
      end
    end
  endfunction

  function automatic dec_t dec_char(input logic [7:0] c);
    dec_t d;
    begin
      d = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
        d.val = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        d.val = 6'(c - 8'h47);
      end else if (c >= 8'h30 && c <= 8'h39) begin
        d.val = 6'(c + 8'd4);
      end else if (c == 8'h2B) begin
        d.val = 6'd62;
      end else if (c == 8'h2F) begin
        d.val = 6'd63;
      end else if (c == CharPad) begin
        d.pad = 1'b1;
      end else begin
        d.bad = 1'b1;
      end
      dec_char = d;
    end
  endfunction

endpackage

@@ rtl/b64_group.sv @@
`timescale 1ns / 1ps

module b64_group (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              accept,
  input  b64_pkg::in_t      in_data,
  output logic              flush,
  output b64_pkg::b64_bundle_t bundle
);
  import b64_pkg::*;

  logic                 mode;
  logic [GroupBits-1:0] group_bits;
  logic [1:0]           group_count;
  logic [1:0]           pad_seen;
  logic                 group_bad;

  logic [GroupBits-1:0] group_bits_next;
  logic [1:0]           group_count_next;
  logic [1:0]           pad_seen_next;
  logic                 group_bad_next;

  dec_t                 dc;
  logic [2:0]           n;
  logic [GroupBits-1:0] bits;
  logic [2:0]           eff;
  logic [2:0]           nbytes;

  always_comb begin
    dc               = dec_char(in_data.data_in);
    n                = {1'b0, group_count} + 3'd1;
    bits             = '0;
    eff              = '0;
    nbytes           = '0;
    flush            = 1'b0;
    bundle           = '0;
    pad_seen_next    = pad_seen;
    group_bad_next   = group_bad;
    group_count_next = group_count;

    if (mode == OpEncode) begin
      group_bits_next = {group_bits[15:0], in_data.data_in};
      flush = (n >= 3'd3) || in_data.end_of_message;
      case (n)
        3'd1:    bits = {group_bits_next[7:0], 16'h0000};
        3'd2:    bits = {group_bits_next[15:0], 8'h00};
        default: bits = group_bits_next;
      endcase
      for (int i = 0; i < MaxResults; i++) begin
        // A group of n bytes gives n + 1 characters, padded out to four.
        if (3'(i) <= n) begin
          bundle.chars[i] = enc_char(bits[GroupBits-1-6*i -: 6]);
        end else begin
          bundle.chars[i] = CharPad;
        end
      end
      bundle.cnt = 3'd4;
      bundle.bad = 1'b0;
    end else begin
      if (dc.pad && pad_seen != 2'd3) begin
        pad_seen_next = pad_seen + 2'd1;
      end
      if (dc.bad) begin
        group_bad_next = 1'b1;
      end
      group_bits_next = {group_bits[17:0], dc.val};
      flush = (n == 3'd4) || in_data.end_of_message;
      case (n)
        3'd1:    bits = {group_bits_next[5:0], 18'h0};
        3'd2:    bits = {group_bits_next[11:0], 12'h0};
        3'd3:    bits = {group_bits_next[17:0], 6'h0};
        default: bits = group_bits_next;
      endcase
      eff = (3'd4 - n) + {1'b0, pad_seen_next};
      if (eff > 3'd3) begin
        eff = 3'd3;
      end
      nbytes = 3'd3 - eff;
      for (int i = 0; i < 3; i++) begin
        bundle.chars[i] = bits[GroupBits-1-8*i -: 8];
      end
      bundle.chars[3] = 8'h00;
      bundle.cnt = nbytes;
      bundle.bad = group_bad_next;
    end

    if (flush) begin
      group_count_next = '0;
    end else begin
      group_count_next = n[1:0];
    end
    bundle.vld = accept && flush && (bundle.cnt != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= OpEncode;
      group_bits  <= '0;
      group_count <= '0;
      pad_seen    <= '0;
      group_bad   <= 1'b0;
    end else if (cfg_wr_en) begin
      mode        <= cfg_wr_data;
      group_bits  <= '0;
      group_count <= '0;
      pad_seen    <= '0;
      group_bad   <= 1'b0;
    end else if (accept) begin
      if (flush) begin
        group_bits  <= '0;
        group_count <= '0;
        pad_seen    <= '0;
        group_bad   <= 1'b0;
      end else begin
        group_bits  <= group_bits_next;
        group_count <= group_count_next;
        pad_seen    <= pad_seen_next;
        group_bad   <= group_bad_next;
      end
    end
  end

endmodule

@@ rtl/b64_emit.sv @@
`timescale 1ns / 1ps

module b64_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  b64_pkg::b64_bundle_t bundle,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b64_pkg::out_t        out_data
);
  import b64_pkg::*;

  logic [3:0][7:0] chars;
  logic [2:0]      cnt;
  logic            bad;
  logic [1:0]      idx;
  logic            valid;
  logic            last;

  assign last = ({1'b0, idx} == cnt - 3'd1);
  // The holding register can take a new group as soon as its last result leaves.
  assign free = !valid || (out_ready && last);

  assign out_valid            = valid;
  assign out_data.data_out    = chars[idx];
  assign out_data.last_of_run = last;
  assign out_data.bad_char    = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (bundle.vld) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && out_ready) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.vld) begin
      chars <= bundle.chars;
      cnt   <= bundle.cnt;
      bad   <= bundle.bad;
    end
  end

endmodule

@@ rtl/base64_stream_codec.sv @@
`timescale 1ns / 1ps

// Streaming base64 encoder and decoder (A-Z a-z 0-9 + / alphabet, '=' padding).
// The one-bit mode register, written through cfg_wr_en and cfg_wr_data, selects
// encode (0) or decode (1); a write also drops any partly gathered group, so it
// should only be done between messages while no results are pending. Each input
// transaction carries one byte or character and an end_of_message flag. The
// group logic folds the item into the current group in the cycle it is taken;
// when the group completes, or the message ends, its results (four characters
// when encoding, zero to three bytes when decoding) are loaded in one step into
// a holding register; from the next cycle the output stage sends them one per
// cycle while out_ready is high, marking the last with last_of_run. An input
// transaction that completes a group or ends a message is accepted only in a
// cycle in which the holding register is empty or is giving up its last
// result; items that only gather into a group never wait. When encoding, the
// output side sets the pace; when decoding, the input side does. In decode
// mode, bad_char is set on every byte of a group that held a character outside
// the alphabet; that character counts as zero. Reset is synchronous and
// clears the mode to encode.

module base64_stream_codec (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  b64_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output b64_pkg::out_t out_data
);
  import b64_pkg::*;

  b64_bundle_t bundle;
  logic        free;
  logic        flush;
  logic        accept;

  // An item that releases results needs room in the holding register; any other
  // item is only folded into the group and can always be taken.
  assign in_ready = free || !flush;
  assign accept   = in_valid && in_ready;

  b64_group u_group (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_data     (in_data),
    .flush       (flush),
    .bundle      (bundle)
  );

  // Output stage: holds one group's results and sends them in order.
  b64_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .bundle    (bundle),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/b64_checker.sv @@
`timescale 1ns / 1ps

module b64_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input b64_pkg::out_t out_data
);
  import b64_pkg::*;

  // A stalled result must stay put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // Nothing is pending right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // With no result pending the block must take input.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A run continues after a non-final result, with one bad_char value throughout.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_run |=>
      out_valid && (out_data.bad_char == $past(out_data.bad_char)))
    else $error("run broken or bad_char changed within a run");

  // The block is ready for input in the first cycle after reset.
  assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind base64_stream_codec b64_checker u_b64_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
